FILE: sv/rccfp_pkg.sv
// Shared types, constants and the CRC-8 byte fold for the RC-channel frame parser.
`timescale 1ns / 1ps
`default_nettype none
package rccfp_pkg;

	localparam int unsigned PAYLOAD_BYTES_DEF = 22;

	localparam logic [7:0] SYNC_ADDR     = 8'hC8;
	localparam logic [7:0] FRAME_TYPE_RC = 8'h16;
	localparam logic [7:0] CRC_POLY_RST  = 8'hD5;

	typedef enum logic [2:0] {
		ST_HUNT = 3'd0,
		ST_LEN  = 3'd1,
		ST_TYPE = 3'd2,
		ST_DATA = 3'd3,
		ST_CRC  = 3'd4,
		ST_EMIT = 3'd5
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic crc_init;
		logic crc_fold;
		logic store_wr;
		logic cnt_clr;
		logic cnt_inc;
		logic rd_load;
	} ctrl_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic is_sync;
		logic is_len;
		logic is_type;
		logic cnt_last;
		logic crc_match;
		logic out_free;
	} dp_status_t;

	// MSB-first CRC-8 fold of one byte; top bit of the polynomial is implicit.
	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: sv/rccfp_datapath.sv
// Datapath of the frame parser: byte compares, CRC register, payload memory and output register.
`timescale 1ns / 1ps
`default_nettype none
module rccfp_datapath
	import rccfp_pkg::*;
#(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] rx_byte,
	input  wire logic       cfg_valid,
	input  wire logic [7:0] cfg_data,
	input  wire ctrl_cmd_t  cmd,
	output dp_status_t      status,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	localparam int unsigned CW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(PAYLOAD_BYTES - 1);
	localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_BYTES + 2);

	logic [7:0]    crc_poly_q;
	logic [7:0]    crc_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic [7:0]    out_data_q;
	logic          out_last_q;
	logic [7:0]    mem [PAYLOAD_BYTES];
	logic [7:0]    crc_base;

	assign crc_base = cmd.crc_init ? 8'h00 : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q  <= CRC_POLY_RST;
			crc_q       <= 8'h00;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				crc_poly_q <= cfg_data;
			end
			if (cmd.crc_init || cmd.crc_fold) begin
				crc_q <= crc8_fold(crc_base, rx_byte, crc_poly_q);
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.rd_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload memory and its registered read port, which is also the output register.
	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			mem[cnt_q] <= rx_byte;
		end
		if (cmd.rd_load) begin
			out_data_q <= mem[cnt_q];
			out_last_q <= (cnt_q == CNT_LAST);
		end
	end

	always_comb begin
		status.is_sync   = (rx_byte == SYNC_ADDR);
		status.is_len    = (rx_byte == LEN_BYTE);
		status.is_type   = (rx_byte == FRAME_TYPE_RC);
		status.cnt_last  = (cnt_q == CNT_LAST);
		status.crc_match = (rx_byte == crc_q);
		status.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

FILE: sv/rccfp_ctrl.sv
// Controller state machine of the frame parser: frame hunting, payload capture and readout.
`timescale 1ns / 1ps
`default_nettype none
module rccfp_ctrl
	import rccfp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_next;
	logic   accept;

	assign s_tready = (state_q != ST_EMIT);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_LEN: begin
				if (accept) begin
					if (status.is_len) begin
						state_next = ST_TYPE;
					end else if (status.is_sync) begin
						state_next = ST_LEN;
					end else begin
						state_next = ST_HUNT;
					end
				end
			end
			ST_TYPE: begin
				if (accept) begin
					if (status.is_type) begin
						state_next = ST_DATA;
					end else if (status.is_sync) begin
						state_next = ST_LEN;
					end else begin
						state_next = ST_HUNT;
					end
				end
			end
			ST_DATA: begin
				if (accept && status.cnt_last) begin
					state_next = ST_CRC;
				end
			end
			ST_CRC: begin
				if (accept) begin
					state_next = status.crc_match ? ST_EMIT : ST_HUNT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.cnt_last) begin
					state_next = ST_HUNT;
				end
			end
			default: begin
				if (accept) begin
					state_next = status.is_sync ? ST_LEN : ST_HUNT;
				end
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_TYPE: begin
				cmd.crc_init = accept && status.is_type;
				cmd.cnt_clr  = accept && status.is_type;
			end
			ST_DATA: begin
				cmd.store_wr = accept;
				cmd.crc_fold = accept;
				cmd.cnt_inc  = accept;
			end
			ST_CRC: begin
				cmd.cnt_clr = accept && status.crc_match;
			end
			ST_EMIT: begin
				cmd.rd_load = status.out_free;
				cmd.cnt_inc = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// The output register is never overwritten while it still holds an untaken beat.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.rd_load |-> status.out_free)
		else $error("readout loaded over a pending output beat");

	// A CRC mismatch emits nothing and drops back to hunting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRC && accept && !status.crc_match) |=> (state_q == ST_HUNT))
		else $error("CRC mismatch did not return to hunting");

	// Loading the final payload byte ends the readout.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && cmd.rd_load && status.cnt_last) |=> (state_q == ST_HUNT))
		else $error("readout did not end after the last payload byte");

	// Payload capture and readout never happen in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.store_wr && cmd.rd_load))
		else $error("payload write and readout overlap");

endmodule
`default_nettype wire

FILE: sv/rc_channel_frame_parser.sv
// Top level of the RC-channel frame parser: controller and datapath wired together.
//
// The parser takes one received serial byte per input beat and hunts for an RC-channel
// frame: sync 0xC8, a length byte equal to PAYLOAD_BYTES + 2, type 0x16, PAYLOAD_BYTES
// payload bytes and a CRC-8 byte (MSB-first, zero start, polynomial from the cfg channel,
// reset 0xD5, covering the type byte and the payload). The CRC register folds a whole
// byte per clock and the payload memory takes one write per clock. When the CRC byte
// matches, the stored payload is read out of the single-port payload memory one beat per
// cycle while m_tready does not stall, and s_tready stays low after the CRC byte until
// the last payload byte is loaded into the output register; the last beat is marked
// with m_tlast. A bad length or type byte drops back to hunting, except a sync
// byte, which restarts at the length step; inside the payload and CRC steps every byte
// is data. After the CRC byte the parser always hunts again; a mismatch emits nothing.
// The final output beat may still wait in the output register while new bytes are taken.
// There is no clearing pass after reset. The polynomial is written through cfg_valid and
// cfg_data, which are always ready, and should only change while no frame is in flight.
`timescale 1ns / 1ps
`default_nettype none
module rc_channel_frame_parser
	import rccfp_pkg::*;
#(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] payload_byte
	output logic            m_tlast,   // last_byte
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data   // [7:0] crc_poly
);

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       cfg_write;

	// The polynomial register takes a write in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	rccfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rccfp_datapath #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (s_tdata),
		.cfg_valid (cfg_write),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

FILE: dv/rc_channel_frame_parser_tb.sv
// Self-checking testbench for the RC-channel frame parser: byte stream in, checked payload out.
`timescale 1ns / 1ps
module rc_channel_frame_parser_tb;
	import rccfp_pkg::*;

	localparam int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
	localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_BYTES_DEF + 2);
	// Settling time for wait_idle, with generous slack beyond a frame's readout.
	localparam int DRAIN_CYCLES = PAYLOAD_BYTES_DEF + 20;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} payload_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	// Predictor state, kept in step with every accepted input beat.
	state_t        pred_phase = ST_HUNT;
	int unsigned   pred_count = 0;
	logic [7:0]    pred_store [PAYLOAD_BYTES];
	logic [7:0]    pred_crc = 8'h00;
	logic [7:0]    pred_poly = CRC_POLY_RST;
	payload_beat_t pending_payload[$];

	logic [7:0] frame_payload [PAYLOAD_BYTES];
	int         mismatch_count = 0;
	int         bytes_sent = 0;
	int         tx_idle_pct = 17;
	int         rx_idle_pct = 66;
	logic       rx_hold = 1'b0;
	int         quiet_cycles = 0;
	event       start_rx_hold;

	rc_channel_frame_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// MSB-first CRC-8 over one byte, implicit x^8 term.
	function automatic logic [7:0] crc_fold_byte(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] acc;
		acc = crc ^ b;
		repeat (8) begin
			acc = acc[7] ? ({acc[6:0], 1'b0} ^ poly) : {acc[6:0], 1'b0};
		end
		return acc;
	endfunction

	// Advance the predicted parser by one received byte and queue any payload it releases.
	task automatic track_parser_byte(input logic [7:0] b);
		payload_beat_t beat;
		case (pred_phase)
			ST_LEN: begin
				if (b == LEN_BYTE) begin
					pred_phase = ST_TYPE;
				end else if (b == SYNC_ADDR) begin
					pred_phase = ST_LEN;
				end else begin
					pred_phase = ST_HUNT;
				end
			end
			ST_TYPE: begin
				if (b == FRAME_TYPE_RC) begin
					pred_phase = ST_DATA;
					pred_count = 0;
					pred_crc = crc_fold_byte(8'h00, b, pred_poly);
				end else if (b == SYNC_ADDR) begin
					pred_phase = ST_LEN;
				end else begin
					pred_phase = ST_HUNT;
				end
			end
			ST_DATA: begin
				// Every byte here is data, a sync byte included.
				pred_store[pred_count] = b;
				pred_crc = crc_fold_byte(pred_crc, b, pred_poly);
				pred_count++;
				if (pred_count >= PAYLOAD_BYTES) begin
					pred_phase = ST_CRC;
				end
			end
			ST_CRC: begin
				if (b == pred_crc) begin
					for (int k = 0; k < PAYLOAD_BYTES; k++) begin
						beat.data = pred_store[k];
						beat.last = (k == PAYLOAD_BYTES - 1);
						pending_payload.push_back(beat);
					end
				end
				pred_phase = ST_HUNT;
			end
			default: begin
				pred_phase = (b == SYNC_ADDR) ? ST_LEN : ST_HUNT;
			end
		endcase
	endtask

	// Offer one byte and hold it until the parser takes it. The valid is left high so that
	// a following byte can go out on the next cycle; a random gap may drop it afterwards.
	task automatic send_byte(input logic [7:0] b);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do begin
			@(posedge clk);
		end while (!s_tready);
		track_parser_byte(b);
		bytes_sent++;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Sync, length, type, frame_payload and its CRC, optionally with one bit flipped.
	task automatic send_frame(input bit corrupt_crc);
		logic [7:0] crc;
		crc = crc_fold_byte(8'h00, FRAME_TYPE_RC, pred_poly);
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			crc = crc_fold_byte(crc, frame_payload[k], pred_poly);
		end
		if (corrupt_crc) begin
			crc = crc ^ 8'(1 << $urandom_range(7));
		end
		send_byte(SYNC_ADDR);
		send_byte(LEN_BYTE);
		send_byte(FRAME_TYPE_RC);
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			send_byte(frame_payload[k]);
		end
		send_byte(crc);
	endtask

	task automatic fill_random_payload();
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			frame_payload[k] = ($urandom_range(9) == 0) ? SYNC_ADDR : 8'($urandom);
		end
	endtask

	// Often header-like values (sync, length or type), so that noise still exercises the early phases.
	function automatic logic [7:0] noise_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			return SYNC_ADDR;
		end else if (pick < 35) begin
			return LEN_BYTE;
		end else if (pick < 45) begin
			return FRAME_TYPE_RC;
		end
		return 8'($urandom);
	endfunction

	// Drop the valid, wait for every predicted beat, then give the block time to settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_payload.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_crc_poly(input logic [7:0] poly);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= poly;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		pred_poly = poly;
		cfg_valid <= 1'b0;
	endtask

	// Malformed headers with resyncs, then a good frame whose payload holds the byte
	// extremes and the sync, length and type values taken as plain data.
	task automatic test_header_cases();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_ADDR);
		send_byte(LEN_BYTE + 8'd1);     // wrong length: back to hunting
		send_byte(SYNC_ADDR);
		send_byte(SYNC_ADDR);           // sync at the length step restarts there
		send_byte(LEN_BYTE);
		send_byte(FRAME_TYPE_RC - 8'd1); // wrong type: back to hunting
		send_byte(SYNC_ADDR);
		send_byte(LEN_BYTE);
		send_byte(SYNC_ADDR);           // sync at the type step goes to the length step
		send_byte(LEN_BYTE);
		send_byte(FRAME_TYPE_RC);
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			frame_payload[k] = 8'(k * 37 + 5);
		end
		frame_payload[0] = 8'h00;
		frame_payload[1] = 8'hFF;
		frame_payload[2] = SYNC_ADDR;
		frame_payload[3] = LEN_BYTE;
		frame_payload[4] = FRAME_TYPE_RC;
		begin
			logic [7:0] crc;
			crc = crc_fold_byte(8'h00, FRAME_TYPE_RC, pred_poly);
			for (int k = 0; k < PAYLOAD_BYTES; k++) begin
				crc = crc_fold_byte(crc, frame_payload[k], pred_poly);
				send_byte(frame_payload[k]);
			end
			send_byte(crc);
		end
		// After the CRC byte the parser hunts again, so a type byte alone does nothing.
		send_byte(FRAME_TYPE_RC);
	endtask

	// A good frame with the zero polynomial and a bad-CRC frame with the all-ones one.
	task automatic test_poly_extremes();
		set_crc_poly(8'h00);
		fill_random_payload();
		send_frame(1'b0);
		set_crc_poly(8'hFF);
		fill_random_payload();
		send_frame(1'b1);
	endtask

	// Mostly well-formed frames with random payload, the rest broken headers,
	// truncated frames, bad CRCs and noise.
	task automatic test_random_traffic(input int n_items);
		int start;
		int pick;
		start = bytes_sent;
		while (bytes_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				fill_random_payload();
				send_frame($urandom_range(7) == 0);
			end else if (pick < 78) begin
				send_byte(SYNC_ADDR);
				if ($urandom_range(1) == 0) begin
					send_byte(noise_byte());
				end else begin
					send_byte(LEN_BYTE);
					send_byte(noise_byte());
				end
			end else if (pick < 88) begin
				send_byte(SYNC_ADDR);
				send_byte(LEN_BYTE);
				send_byte(FRAME_TYPE_RC);
				repeat ($urandom_range(1, PAYLOAD_BYTES - 1)) send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(noise_byte());
			end
		end
	endtask

	// The receiver stops for a long stretch while a good frame and then more bytes keep
	// coming, so the output backs up and the parser has to stall its input.
	task automatic test_backpressure();
		-> start_rx_hold;
		fill_random_payload();
		send_frame(1'b0);
		repeat (4) send_byte(noise_byte());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 17;
		rx_idle_pct = 66;
		test_header_cases();
		test_poly_extremes();

		tx_idle_pct = 66;
		rx_idle_pct = 17;
		set_crc_poly(8'($urandom));
		test_random_traffic(10);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_crc_poly(CRC_POLY_RST);
		test_backpressure();

		wait_idle();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Receiver: random stalls, or a forced hold while rx_hold is set.
	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		forever begin
			@(start_rx_hold);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("%0t: %s mismatch: got 0x%02h, expected 0x%02h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Every output beat is matched against the oldest predicted payload byte.
	always @(posedge clk) begin
		payload_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_payload.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 8'h00);
			end else begin
				want = pending_payload.pop_front();
				if (m_tdata !== want.data) begin
					report_mismatch("payload_byte", m_tdata, want.data);
				end
				if (m_tlast !== want.last) begin
					report_mismatch("last_byte", 8'(m_tlast), 8'(want.last));
				end
			end
		end
	end

	// Watchdog: ends the run after too many cycles in which no handshake completes.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
